@@ rtl/core/dcv_pkg.sv @@
// Shared types, constants and the color distance function for the dominant color vote block.
package dcv_pkg;

    localparam int MAX_BUCKETS_DEF = 8;

    localparam int COLOR_W = 24;
    localparam int COUNT_W = 6;
    localparam int DIST_W  = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
    localparam logic [COLOR_W-1:0] WHITE_RGB = 24'hFF_FFFF;
    localparam logic [DIST_W-1:0]  TEXT_TH_RST  = 10'd80;
    localparam logic [DIST_W-1:0]  MERGE_TH_RST = 10'd36;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR_VALID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_COLOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_VALID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_THRESHOLD  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEXT,
        ST_SCAN,
        ST_VOTE
    } dcv_state_t;

    typedef struct packed {
        logic load_sample;
        logic start_idx;
        logic scan_en;
        logic vote_en;
        logic emit;
    } dcv_cmd_t;

    typedef struct packed {
        logic skip;
        logic last;
        logic scan_done;
        logic vote_done;
        logic out_free;
    } dcv_status_t;

    // L1 distance of two packed colors, red in the top byte
    function automatic logic [DIST_W-1:0] l1_dist(input logic [COLOR_W-1:0] p,
                                                  input logic [COLOR_W-1:0] q);
        logic [7:0] dr;
        logic [7:0] dg;
        logic [7:0] db;
        dr = (p[23:16] > q[23:16]) ? p[23:16] - q[23:16] : q[23:16] - p[23:16];
        dg = (p[15:8]  > q[15:8])  ? p[15:8]  - q[15:8]  : q[15:8]  - p[15:8];
        db = (p[7:0]   > q[7:0])   ? p[7:0]   - q[7:0]   : q[7:0]   - p[7:0];
        return {2'b00, dr} + {2'b00, dg} + {2'b00, db};
    endfunction

endpackage

@@ rtl/core/dcv_ctrl.sv @@
// Sequencer for the dominant color vote: accept, text check, bucket scan, vote.
module dcv_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  dcv_pkg::dcv_status_t status,
    output dcv_pkg::dcv_cmd_t   cmd
);

    dcv_pkg::dcv_state_t state_reg;
    dcv_pkg::dcv_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dcv_pkg::ST_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = dcv_pkg::ST_TEXT;
                end
            end
            dcv_pkg::ST_TEXT:
            begin
                if (status.skip)
                begin
                    state_next = status.last ? dcv_pkg::ST_VOTE : dcv_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = dcv_pkg::ST_SCAN;
                end
            end
            dcv_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = status.last ? dcv_pkg::ST_VOTE : dcv_pkg::ST_IDLE;
                end
            end
            dcv_pkg::ST_VOTE:
            begin
                if (status.vote_done && status.out_free)
                begin
                    state_next = dcv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dcv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            dcv_pkg::ST_IDLE:
            begin
                s_ready         = 1'b1;
                cmd.load_sample = s_valid;
            end
            dcv_pkg::ST_TEXT:
            begin
                // both the scan and the vote walk from bucket zero
                cmd.start_idx = !status.skip || status.last;
            end
            dcv_pkg::ST_SCAN:
            begin
                cmd.scan_en   = 1'b1;
                cmd.start_idx = status.scan_done && status.last;
            end
            dcv_pkg::ST_VOTE:
            begin
                cmd.vote_en = 1'b1;
                cmd.emit    = status.vote_done && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/dcv_datapath.sv @@
// Datapath: config registers, bucket memory, scan and vote compare, output register.
module dcv_datapath #(
    parameter int MAX_BUCKETS = dcv_pkg::MAX_BUCKETS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dcv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dcv_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [dcv_pkg::COLOR_W-1:0]         sample_color,
    input  logic                                sample_last,
    input  dcv_pkg::dcv_cmd_t                   cmd,
    output dcv_pkg::dcv_status_t                status,
    output logic [dcv_pkg::COLOR_W-1:0]         out_color,
    output logic                                out_from_fallback,
    output logic                                out_overflow,
    output logic                                out_valid,
    input  logic                                out_ready
);

    localparam int IDX_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
    localparam int WORD_W = dcv_pkg::COUNT_W + dcv_pkg::COLOR_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_BUCKETS);

    // configuration
    logic [dcv_pkg::COLOR_W-1:0] text_color_reg;
    logic                        text_valid_reg;
    logic [dcv_pkg::COLOR_W-1:0] fallback_reg;
    logic                        fallback_valid_reg;
    logic [dcv_pkg::DIST_W-1:0]  text_th_reg;
    logic [dcv_pkg::DIST_W-1:0]  merge_th_reg;

    // sample and walk control
    logic [dcv_pkg::COLOR_W-1:0] sample_reg;
    logic                        last_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic                        pend_reg;
    logic [IDX_W-1:0]            pend_idx_reg;
    logic [CNT_W-1:0]            used_reg;
    logic                        ovf_reg;

    // vote leader
    logic [dcv_pkg::COUNT_W-1:0] best_cnt_reg;
    logic [dcv_pkg::COLOR_W-1:0] best_color_reg;
    logic [dcv_pkg::DIST_W-1:0]  best_dist_reg;

    // output word
    logic [dcv_pkg::COLOR_W-1:0] out_color_reg;
    logic                        out_fb_reg;
    logic                        out_ovf_reg;
    logic                        out_valid_reg;

    // bucket memory: count above color
    logic [WORD_W-1:0]           mem [MAX_BUCKETS];
    logic [WORD_W-1:0]           rdata_reg;

    logic [dcv_pkg::COLOR_W-1:0] rd_color;
    logic [dcv_pkg::COUNT_W-1:0] rd_cnt;
    logic [dcv_pkg::COUNT_W-1:0] sat_cnt;
    logic [dcv_pkg::DIST_W-1:0]  merge_dist;
    logic [dcv_pkg::DIST_W-1:0]  text_dist;
    logic [dcv_pkg::DIST_W-1:0]  fb_dist;
    logic                        more;
    logic                        hit;
    logic                        miss;
    logic                        better;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [WORD_W-1:0]           wr_data;

    always_comb
    begin
        rd_color   = rdata_reg[dcv_pkg::COLOR_W-1:0];
        rd_cnt     = rdata_reg[WORD_W-1:dcv_pkg::COLOR_W];
        sat_cnt    = (rd_cnt == dcv_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
        merge_dist = dcv_pkg::l1_dist(rd_color, sample_reg);
        text_dist  = dcv_pkg::l1_dist(sample_reg, text_color_reg);
        fb_dist    = dcv_pkg::l1_dist(rd_color, fallback_reg);
        more       = idx_reg < used_reg;
        hit        = cmd.scan_en && pend_reg && (merge_dist < merge_th_reg);
        miss       = cmd.scan_en && !hit && !more;
        // first bucket seeds the leader; ties go to a later bucket strictly closer to a valid fallback
        better     = (pend_idx_reg == '0) || (rd_cnt > best_cnt_reg) ||
                     ((rd_cnt == best_cnt_reg) && fallback_valid_reg &&
                      (fb_dist < best_dist_reg));
        rd_en      = (cmd.scan_en && !hit && more) || (cmd.vote_en && more);
        rd_addr    = idx_reg[IDX_W-1:0];
        wr_en      = hit || (miss && (used_reg < FULL));
        wr_addr    = hit ? pend_idx_reg : used_reg[IDX_W-1:0];
        wr_data    = hit ? {sat_cnt, rd_color}
                         : {dcv_pkg::COUNT_W'(1), sample_reg};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg     <= '0;
            text_valid_reg     <= 1'b0;
            fallback_reg       <= dcv_pkg::WHITE_RGB;
            fallback_valid_reg <= 1'b0;
            text_th_reg        <= dcv_pkg::TEXT_TH_RST;
            merge_th_reg       <= dcv_pkg::MERGE_TH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcv_pkg::CFG_TEXT_COLOR:       text_color_reg     <= cfg_data;
                dcv_pkg::CFG_TEXT_COLOR_VALID: text_valid_reg     <= cfg_data[0];
                dcv_pkg::CFG_FALLBACK_COLOR:   fallback_reg       <= cfg_data;
                dcv_pkg::CFG_FALLBACK_VALID:   fallback_valid_reg <= cfg_data[0];
                dcv_pkg::CFG_TEXT_THRESHOLD:   text_th_reg  <= cfg_data[dcv_pkg::DIST_W-1:0];
                dcv_pkg::CFG_MERGE_THRESHOLD:  merge_th_reg <= cfg_data[dcv_pkg::DIST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= sample_color;
            last_reg   <= sample_last;
        end
        if (cmd.vote_en && pend_reg && better)
        begin
            best_cnt_reg   <= rd_cnt;
            best_color_reg <= rd_color;
            best_dist_reg  <= fb_dist;
        end
        if (cmd.emit)
        begin
            if (used_reg == '0)
            begin
                out_color_reg <= fallback_valid_reg ? fallback_reg : dcv_pkg::WHITE_RGB;
                out_fb_reg    <= 1'b1;
                out_ovf_reg   <= 1'b0;
            end
            else
            begin
                out_color_reg <= best_color_reg;
                out_fb_reg    <= 1'b0;
                out_ovf_reg   <= ovf_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            used_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_idx)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (rd_en)
            begin
                idx_reg      <= idx_reg + 1'b1;
                pend_reg     <= 1'b1;
                pend_idx_reg <= rd_addr;
            end
            else if (cmd.scan_en || cmd.vote_en)
            begin
                pend_reg <= 1'b0;
            end

            if (cmd.emit)
            begin
                used_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (miss)
            begin
                if (used_reg < FULL)
                begin
                    used_reg <= used_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.skip      = text_valid_reg && (text_dist < text_th_reg);
        status.last      = last_reg;
        status.scan_done = hit || miss;
        status.vote_done = !pend_reg && !more;
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_color         = out_color_reg;
    assign out_from_fallback = out_fb_reg;
    assign out_overflow      = out_ovf_reg;
    assign out_valid         = out_valid_reg;

endmodule

@@ rtl/core/dominant_color_vote_unit.sv @@
// Top level of the dominant color vote: stream ports, config port, controller and datapath.
//
// Takes a run of RGB sample words (tlast marks the final one) and returns one word with the
// dominant background color of the run. A sample within text_threshold (L1) of an enabled
// text color is skipped; otherwise it joins the first bucket closer than merge_threshold or
// opens a new bucket, up to MAX_BUCKETS; colors that find no room set the overflow flag.
// Counts saturate at 63. On the last sample the bucket with the highest count wins, a later
// equal bucket winning only when a valid fallback color is set and it is strictly closer to
// it; a run with no bucket returns the fallback color (or white) with from_fallback set.
// The bucket store is cleared when the result is loaded into the output register.
// Timing: the bucket memory has one registered read port and is walked one bucket per
// cycle. A skipped sample only passes the text check; any other sample walks the buckets
// until it merges into one or opens or drops a bucket, and the last sample then adds a vote
// walk over the used buckets. The result sits in an output register, so a new run can start
// while it waits; the vote only stalls if the previous result is unread.
// Configuration is to be written only while the block is idle; the block itself does not enforce this.
module dominant_color_vote_unit #(
    parameter int MAX_BUCKETS = dcv_pkg::MAX_BUCKETS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                            s_axis_tlast,   // last_sample
    // result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,   // red_out, green_out, blue_out
    output logic [1:0]                      m_axis_tuser,   // from_fallback, bucket_overflow
    // configuration
    input  logic                            cfg_we,
    input  logic [dcv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcv_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dcv_pkg::dcv_cmd_t           cmd;
    dcv_pkg::dcv_status_t        status;
    logic [dcv_pkg::COLOR_W-1:0] sample_color;
    logic [dcv_pkg::COLOR_W-1:0] out_color;
    logic                        out_from_fallback;
    logic                        out_overflow;

    // internal color layout keeps red in the top byte
    assign sample_color = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

    dcv_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    dcv_datapath #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .sample_color      (sample_color),
        .sample_last       (s_axis_tlast),
        .cmd               (cmd),
        .status            (status),
        .out_color         (out_color),
        .out_from_fallback (out_from_fallback),
        .out_overflow      (out_overflow),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready)
    );

    assign m_axis_tdata = {out_color[7:0], out_color[15:8], out_color[23:16]};
    assign m_axis_tuser = {out_overflow, out_from_fallback};

    // a result is only loaded once the vote walk is finished and the output slot is free
    a_emit_gated: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (status.vote_done && status.out_free))
        else $error("result loaded before vote finished or into a busy output");

    // after a sample is taken the block is busy with it
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sample |=> !s_axis_tready)
        else $error("input ready right after a sample was taken");

    // scan and vote never share the bucket read port
    a_walk_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.scan_en && cmd.vote_en))
        else $error("scan and vote active together");

    // a loaded result is presented on the next cycle
    a_emit_visible: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

@@ verif/tb_dominant_color_vote_unit.sv @@
// Self-checking testbench for dominant_color_vote_unit: directed runs, then random runs.
`timescale 1ns / 100ps

// One expected result word, in the order the fields leave the block
typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       from_fb;
    logic       overflow;
} vote_result_t;

// One full set of configuration register values
typedef struct {
    logic [23:0] txt_color;
    bit          txt_on;
    logic [23:0] fb_color;
    bit          fb_on;
    int          txt_th;
    int          merge_th;
} vote_setting_t;

class vote_scoreboard;
    // mirror of the configuration registers
    logic [23:0] txt_color;
    bit          txt_on;
    logic [23:0] fb_color;
    bit          fb_on;
    int          txt_th;
    int          merge_th;

    // mirror of the bucket store; colors packed red in the top byte
    logic [23:0] bkt_color [dcv_pkg::MAX_BUCKETS_DEF];
    int          bkt_count [dcv_pkg::MAX_BUCKETS_DEF];
    int          used;
    bit          dropped;

    vote_result_t pending_votes [$];
    int           err_count;

    function new();
        txt_color = '0;
        txt_on    = 0;
        fb_color  = dcv_pkg::WHITE_RGB;
        fb_on     = 0;
        txt_th    = int'(dcv_pkg::TEXT_TH_RST);
        merge_th  = int'(dcv_pkg::MERGE_TH_RST);
        err_count = 0;
        clear_store();
    endfunction

    function void clear_store();
        for (int i = 0; i < dcv_pkg::MAX_BUCKETS_DEF; i++)
        begin
            bkt_color[i] = '0;
            bkt_count[i] = 0;
        end
        used    = 0;
        dropped = 0;
    endfunction

    function int rgb_distance(logic [23:0] p, logic [23:0] q);
        int sum;
        int a;
        int b;
        sum = 0;
        for (int ch = 0; ch < 3; ch++)
        begin
            a = int'(p[ch*8 +: 8]);
            b = int'(q[ch*8 +: 8]);
            sum += (a > b) ? a - b : b - a;
        end
        return sum;
    endfunction

    function int outstanding();
        return pending_votes.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] d);
        case (idx)
            dcv_pkg::CFG_TEXT_COLOR:       txt_color = d;
            dcv_pkg::CFG_TEXT_COLOR_VALID: txt_on    = d[0];
            dcv_pkg::CFG_FALLBACK_COLOR:   fb_color  = d;
            dcv_pkg::CFG_FALLBACK_VALID:   fb_on     = d[0];
            dcv_pkg::CFG_TEXT_THRESHOLD:   txt_th    = int'(d[9:0]);
            dcv_pkg::CFG_MERGE_THRESHOLD:  merge_th  = int'(d[9:0]);
            default: ;
        endcase
    endfunction

    // Bucket vote over the current store; called on the last sample
    function vote_result_t pick_background();
        vote_result_t r;
        logic [23:0]  win;
        int           best;
        best = 0;
        if (used == 0)
        begin
            win       = fb_on ? fb_color : dcv_pkg::WHITE_RGB;
            r.from_fb = 1'b1;
        end
        else
        begin
            for (int i = 1; i < used; i++)
            begin
                if (bkt_count[i] > bkt_count[best])
                    best = i;
                else if (bkt_count[i] == bkt_count[best] && fb_on &&
                         rgb_distance(bkt_color[i], fb_color) <
                         rgb_distance(bkt_color[best], fb_color))
                    best = i;
            end
            win       = bkt_color[best];
            r.from_fb = 1'b0;
        end
        r.red      = win[23:16];
        r.green    = win[15:8];
        r.blue     = win[7:0];
        r.overflow = dropped;
        return r;
    endfunction

    // Accepted sample word: red in [7:0], green in [15:8], blue in [23:16]
    function void note_sample(logic [23:0] word, logic last);
        logic [23:0] s;
        bit          hit;
        s   = {word[7:0], word[15:8], word[23:16]};
        hit = 0;
        if (!(txt_on && rgb_distance(s, txt_color) < txt_th))
        begin
            for (int i = 0; i < used; i++)
            begin
                if (!hit && rgb_distance(s, bkt_color[i]) < merge_th)
                begin
                    if (bkt_count[i] < int'(dcv_pkg::COUNT_MAX))
                        bkt_count[i]++;
                    hit = 1;
                end
            end
            if (!hit)
            begin
                if (used < dcv_pkg::MAX_BUCKETS_DEF)
                begin
                    bkt_color[used] = s;
                    bkt_count[used] = 1;
                    used++;
                end
                else
                    dropped = 1;
            end
        end
        if (last)
        begin
            pending_votes.push_back(pick_background());
            clear_store();
        end
    endfunction

    task flag(string msg);
        err_count++;
        if (err_count <= 40)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_word(logic [23:0] word, logic [1:0] flags);
        vote_result_t want;
        if (pending_votes.size() == 0)
        begin
            flag($sformatf("result word %h user %b with nothing expected", word, flags));
            return;
        end
        want = pending_votes.pop_front();
        if (word[7:0] !== want.red)
            flag($sformatf("red_out %h, expected %h", word[7:0], want.red));
        if (word[15:8] !== want.green)
            flag($sformatf("green_out %h, expected %h", word[15:8], want.green));
        if (word[23:16] !== want.blue)
            flag($sformatf("blue_out %h, expected %h", word[23:16], want.blue));
        if (flags[0] !== want.from_fb)
            flag($sformatf("from_fallback %b, expected %b", flags[0], want.from_fb));
        if (flags[1] !== want.overflow)
            flag($sformatf("bucket_overflow %b, expected %b", flags[1], want.overflow));
    endtask
endclass

module tb_dominant_color_vote_unit;

    // indexes past the register list; writes there must change nothing
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    // cycles without any accepted word before the run is declared hung;
    // the slowest legal gap is a full vote plus long random stalls or the
    // settle pause, so this is generous
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEM_TARGET = 1100;
    localparam int PHASE_ITEMS = 90;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // red[7:0], green[15:8], blue[23:16]
    logic        s_axis_tlast  = 1'b0; // last_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // red_out[7:0], green_out[15:8], blue_out[23:16]
    logic [1:0]  m_axis_tuser;         // from_fallback[0], bucket_overflow[1]
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = '0;
    logic [23:0] cfg_data      = '0;

    vote_scoreboard board;
    vote_setting_t  cur_set;
    int             src_idle_pct  = 0;
    int             sink_stall_pct = 0;
    int             items_sent    = 0;
    int             quiet_cycles  = 0;

    dominant_color_vote_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: check accepted words, throttle tready, watch for a hang.
    // Sampling right after the edge sees the pre-edge values of all signals.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_word(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_dominant_color_vote_unit failed");
                $finish;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Random per-channel offset in [-amt, amt], clamped to the channel range
    function automatic logic [23:0] nudge(logic [23:0] c, int amt);
        logic [23:0] r;
        int          v;
        for (int ch = 0; ch < 3; ch++)
        begin
            v = int'(c[ch*8 +: 8]) + int'($urandom_range(0, 2 * amt)) - amt;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            r[ch*8 +: 8] = v[7:0];
        end
        return r;
    endfunction

    // Thresholds: mostly useful values, sometimes the extremes
    function automatic int pick_threshold();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 766;
            2:       return 767;
            3:       return 1023;
            default: return $urandom_range(1, 120);
        endcase
    endfunction

    // One sample word; c is packed red in the top byte. Returns after the accepting edge.
    task automatic push_sample(logic [23:0] c, bit last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c[7:0], c[15:8], c[23:16]};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        board.note_sample({c[7:0], c[15:8], c[23:16]}, last);
        items_sent++;
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [23:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        board.write_reg(idx, d);
    endtask

    task automatic apply_setting(vote_setting_t c);
        cur_set = c;
        cfg_write(dcv_pkg::CFG_TEXT_COLOR, c.txt_color);
        cfg_write(dcv_pkg::CFG_TEXT_COLOR_VALID, {23'd0, c.txt_on});
        cfg_write(dcv_pkg::CFG_FALLBACK_COLOR, c.fb_color);
        cfg_write(dcv_pkg::CFG_FALLBACK_VALID, {23'd0, c.fb_on});
        cfg_write(dcv_pkg::CFG_TEXT_THRESHOLD, 24'(c.txt_th));
        cfg_write(dcv_pkg::CFG_MERGE_THRESHOLD, 24'(c.merge_th));
        if ($urandom_range(0, 2) == 0)
        begin
            cfg_write(CFG_SPARE_A, 24'($urandom));
            cfg_write(CFG_SPARE_B, 24'($urandom));
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drain all results, then give the block time to finish any non-last sample
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random run, always closed by a last sample
    task automatic send_run();
        logic [23:0] pal [4];
        logic [23:0] c;
        logic [23:0] c2;
        logic [2:0]  m;
        int          kind;
        int          len;
        int          npal;
        int          amt;
        int          n2;
        kind = $urandom_range(0, 29);
        if (kind <= 19)
        begin
            // clustered colors around a small palette, sometimes text-colored noise
            npal = $urandom_range(1, 4);
            for (int i = 0; i < 4; i++)
            begin
                m = 3'($urandom);
                pal[i] = ($urandom_range(0, 3) == 0) ?
                         {{8{m[2]}}, {8{m[1]}}, {8{m[0]}}} : 24'($urandom);
            end
            len = $urandom_range(1, 24);
            amt = $urandom_range(0, 24);
            for (int k = 0; k < len; k++)
            begin
                c = nudge(pal[$urandom_range(0, npal - 1)], amt);
                if (cur_set.txt_on && $urandom_range(0, 7) == 0)
                    c = nudge(cur_set.txt_color, 10);
                push_sample(c, k == len - 1);
            end
        end
        else if (kind <= 24)
        begin
            // scattered colors: tends to fill the store and drop
            len = $urandom_range(6, 20);
            for (int k = 0; k < len; k++)
                push_sample(24'($urandom), k == len - 1);
        end
        else if (kind == 25)
        begin
            // long runs of one or two colors so counts hit the ceiling
            c   = 24'($urandom);
            c2  = 24'($urandom);
            len = $urandom_range(62, 66);
            n2  = ($urandom_range(0, 1) == 1) ? $urandom_range(62, 66) : 0;
            for (int k = 0; k < len; k++)
                push_sample(c, n2 == 0 && k == len - 1);
            for (int k = 0; k < n2; k++)
                push_sample(c2, k == n2 - 1);
        end
        else if (kind <= 27)
        begin
            // samples around the text color: often an empty run
            len = $urandom_range(1, 6);
            amt = $urandom_range(0, 30);
            for (int k = 0; k < len; k++)
                push_sample(nudge(cur_set.txt_color, amt), k == len - 1);
        end
        else
            push_sample(24'($urandom), 1);
    endtask

    task automatic directed_runs();
        vote_setting_t s;
        // reset settings: black, white, then a merge of two close grays
        push_sample(24'h000000, 1);
        push_sample(24'hFFFFFF, 1);
        push_sample(24'h808080, 0);
        push_sample(24'h828282, 0);
        push_sample(24'h202020, 1);

        settle();
        s = '{24'h102030, 1, 24'h00FF00, 1, 80, 36};
        apply_setting(s);
        // only sample is text colored: empty run, fallback returned
        push_sample(24'h102030, 1);
        // tie between two buckets, the later one is closer to the fallback
        push_sample(24'hFF0000, 0);
        push_sample(24'h00F000, 1);
        // ten distinct colors: the last two find no room
        push_sample(24'hFFFFFF, 0);
        push_sample(24'hFF0000, 0);
        push_sample(24'h0000FF, 0);
        push_sample(24'hFFFF00, 0);
        push_sample(24'hFF00FF, 0);
        push_sample(24'h00FFFF, 0);
        push_sample(24'h808080, 0);
        push_sample(24'hC0C0C0, 0);
        push_sample(24'h804000, 0);
        push_sample(24'h400080, 1);

        settle();
        // zero thresholds: nothing skipped, nothing merges, tie without fallback
        s = '{24'h000000, 1, 24'hFFFFFF, 0, 0, 0};
        apply_setting(s);
        push_sample(24'h123456, 0);
        push_sample(24'h123456, 1);

        settle();
        // maximal text threshold: everything skipped, white returned
        s = '{24'hFFFFFF, 1, 24'h5A5A5A, 0, 1023, 1023};
        apply_setting(s);
        push_sample(24'hABCDEF, 1);

        settle();
        // maximal merge threshold: opposite colors still merge
        s = '{24'h000000, 0, 24'h000000, 1, 0, 1023};
        apply_setting(s);
        push_sample(24'h00FF00, 0);
        push_sample(24'hFF00FF, 1);
    endtask

    initial
    begin
        vote_setting_t s;
        int            phase;
        int            phase_start;
        int            runs;

        board = new();
        cur_set = '{24'h000000, 0, dcv_pkg::WHITE_RGB, 0,
                    int'(dcv_pkg::TEXT_TH_RST), int'(dcv_pkg::MERGE_TH_RST)};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_runs();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            s.txt_color = 24'($urandom);
            s.txt_on    = 1'($urandom_range(0, 1));
            s.fb_color  = 24'($urandom);
            s.fb_on     = 1'($urandom_range(0, 1));
            s.txt_th    = pick_threshold();
            s.merge_th  = pick_threshold();
            // first phases pin the extremes; the fourth pins fallback on and the reset merge threshold
            case (phase)
                0: s.merge_th = 1023;
                1:
                begin
                    s.merge_th = 0;
                    s.txt_th   = 0;
                    s.txt_on   = 1;
                end
                2:
                begin
                    s.txt_on = 1;
                    s.txt_th = 1023;
                end
                3:
                begin
                    s.fb_on    = 1;
                    s.merge_th = 36;
                end
                default: ;
            endcase
            apply_setting(s);

            // idle modes: none, sender only, receiver only, both
            case (phase % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 63;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 63;
                end
                default:
                begin
                    src_idle_pct   = 26;
                    sink_stall_pct = 26;
                end
            endcase

            phase_start = items_sent;
            runs = 0;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET)
            begin
                send_run();
                runs++;
                // mid-stream hold: let every pending result drain first
                if (phase == 4 && runs == 3)
                begin
                    s_axis_tvalid <= 1'b0;
                    do
                        @(posedge clk);
                    while (board.outstanding() != 0);
                end
            end
            phase++;
        end

        settle();
        if (board.err_count == 0 && board.outstanding() == 0)
            $display("tb_dominant_color_vote_unit passed");
        else
            $display("tb_dominant_color_vote_unit failed");
        $finish;
    end

endmodule
